FILE: hw/rtl/rhbw_pkg.sv
// Shared types, constants and helpers for the received height bitmap block.
// No dependencies; imported by rhbw_bitmap, received_height_bitmap_watermark, the checker and the testbench.
package rhbw_pkg;

    localparam int WORD_BITS       = 64;
    localparam int POS_W           = 6;
    localparam int DEF_SPAN_WORDS  = 4;
    localparam int IN_TDATA_W      = 128;
    localparam int IN_TUSER_W      = 1;
    localparam int OUT_TDATA_W     = 264;
    localparam int OUT_TUSER_W     = 2;

    localparam logic [WORD_BITS-1:0] WORD_ONES = {WORD_BITS{1'b1}};
    localparam logic [WORD_BITS-1:0] WORD_ONE  = {{(WORD_BITS-1){1'b0}}, 1'b1};

    localparam logic MODE_MARK  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_NEW = 2'd0,
        ST_DUP = 2'd1,
        ST_LOW = 2'd2,
        ST_OUT = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MARK,
        S_ADV,
        S_QRY,
        S_DONE
    } t_state;

    function automatic logic [POS_W-1:0] first_one(input logic [WORD_BITS-1:0] v);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                p = POS_W'(i);
            end
        end
        return p;
    endfunction

endpackage

FILE: hw/rtl/rhbw_bitmap.sv
// Arrival bitmap store: one word per span word, registered synchronous read.
// Per-word valid flags give a cleared bitmap at once. Depends on rhbw_pkg.
module rhbw_bitmap
    import rhbw_pkg::*;
#(
    parameter int SPAN_WORDS = DEF_SPAN_WORDS,
    parameter int WW         = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [WW-1:0]        i_waddr,
    input  logic [WORD_BITS-1:0] i_wdata,
    input  logic [WW-1:0]        i_raddr,
    input  logic                 i_clr,
    output logic [WORD_BITS-1:0] o_rdata
);

    logic [WORD_BITS-1:0]  r_mem [SPAN_WORDS];
    logic [SPAN_WORDS-1:0] r_vld;
    logic [WORD_BITS-1:0]  r_rdata;
    logic                  r_rvld;
    logic                  fwd;

    assign fwd = i_we && (i_waddr == i_raddr);

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= fwd ? i_wdata : r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rvld <= fwd ? 1'b1 : r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

FILE: hw/rtl/received_height_bitmap_watermark.sv
// Top level: sequencer, watermark and window registers, word scan.
// Depends on rhbw_pkg and rhbw_bitmap.
//
// Requests enter on the s_axis channel: tuser carries the mode (mark or
// query), tdata the height and the query end height. One response per
// request leaves on m_axis: tuser carries the status, tdata the run found
// flag, run start, run end, connected height and window base.
// A request is taken only while the sequencer is idle. After accept, a mark
// below the watermark or outside the window and a query with nothing to
// examine go CHECK, DONE; a mark already set goes CHECK, MARK, DONE; a new
// mark goes CHECK, MARK, ADV, DONE, where ADV reads k (1..SPAN_WORDS)
// bitmap words in the watermark scan; a query goes CHECK, QRY, DONE, QRY
// reading k words. One bitmap word is read per cycle from the one-read,
// one-write store; the next request is taken in the cycle after the response loads.
// Reset puts the window at 0 and the watermark at 1 and clears the bitmap
// through its per-word valid flags in the same cycle; no clearing pass.
// The response register holds while the receiver stalls; the sequencer
// waits in its final state until the register frees, while input is held.
module received_height_bitmap_watermark
    import rhbw_pkg::*;
#(
    parameter int SPAN_WORDS = DEF_SPAN_WORDS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [63:0] height, [127:64] limit_height
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [0] mode
    input  logic [IN_TUSER_W-1:0]  i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [0] run_found, [64:1] run_start, [128:65] run_end,
    // [192:129] connected_height, [256:193] window_start, [263:257] zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // [1:0] status
    output logic [OUT_TUSER_W-1:0] o_m_axis_tuser
);

    localparam int WW    = (SPAN_WORDS > 1) ? $clog2(SPAN_WORDS) : 1;
    localparam int OFF_W = WW + POS_W;
    localparam logic [WW-1:0]        LAST_WORD = WW'(SPAN_WORDS - 1);
    localparam logic [OFF_W-1:0]     MAX_OFF   = {LAST_WORD, {POS_W{1'b1}}};
    localparam logic [WORD_BITS-1:0] SPAN_BITS = WORD_BITS'(SPAN_WORDS * WORD_BITS);

    t_state                r_state, n_state;
    logic                  r_mode, n_mode;
    logic [WORD_BITS-1:0]  r_h, n_h;
    logic [WORD_BITS-1:0]  r_endh, n_endh;
    logic [WORD_BITS-1:0]  r_base, n_base;
    logic [WORD_BITS-1:0]  r_lm, n_lm;
    logic [OFF_W-1:0]      r_lm_off, n_lm_off;
    logic [WW-1:0]         r_word, n_word;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [OFF_W-1:0]      r_hi, n_hi;
    logic                  r_run, n_run;
    t_status               r_status, n_status;
    logic                  r_found, n_found;
    logic [OFF_W-1:0]      r_rs_off, n_rs_off;
    logic [OFF_W-1:0]      r_re_off, n_re_off;
    logic                  r_out_vld, n_out_vld;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;
    logic [OUT_TUSER_W-1:0] r_out_user, n_out_user;

    logic                  accept;
    logic                  out_free;
    logic                  mem_we;
    logic                  mem_clr;
    logic [WORD_BITS-1:0]  mem_wdata;
    logic [WORD_BITS-1:0]  rd_word;

    logic [WORD_BITS-1:0]  h_off;
    logic [WORD_BITS-1:0]  e_off;
    logic                  mark_low;
    logic                  mark_out;
    logic                  chk_mark_go;
    logic                  q_empty;
    logic                  chk_qry_go;
    logic [OFF_W-1:0]      q_lo;
    logic [OFF_W-1:0]      q_hi;

    logic [WW-1:0]         lm_w;
    logic [WORD_BITS-1:0]  below;
    logic [WORD_BITS-1:0]  eff;
    logic [WORD_BITS-1:0]  range_m;
    logic                  is_hiw;
    logic                  is_last;
    logic                  mark_dup;
    logic                  adv_hit;
    logic [POS_W-1:0]      adv_p;
    logic [WORD_BITS-1:0]  cand;
    logic                  cand_hit;
    logic [POS_W-1:0]      cand_p;
    logic [WORD_BITS-1:0]  term_s;
    logic                  term_s_hit;
    logic [POS_W-1:0]      term_s_p;
    logic [WORD_BITS-1:0]  term_r;
    logic                  term_r_hit;
    logic [POS_W-1:0]      term_r_p;
    logic                  qry_fin;

    rhbw_bitmap #(
        .SPAN_WORDS (SPAN_WORDS),
        .WW         (WW)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (r_word),
        .i_wdata (mem_wdata),
        .i_raddr (n_word),
        .i_clr   (mem_clr),
        .o_rdata (rd_word)
    );

    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_vld || i_m_axis_tready;

    // request classification
    always_comb begin
        h_off       = r_h - r_base;
        e_off       = r_endh - r_base;
        mark_low    = r_h < r_lm;
        mark_out    = (r_h < r_base) || (h_off >= SPAN_BITS);
        chk_mark_go = (r_mode == MODE_MARK) && !mark_low && !mark_out;
        q_empty     = (r_h > r_endh) || (r_endh < r_base) ||
                      ((r_h >= r_base) && (h_off >= SPAN_BITS));
        chk_qry_go  = (r_mode == MODE_QUERY) && !q_empty;
        q_lo        = (r_h >= r_base) ? h_off[OFF_W-1:0] : '0;
        q_hi        = (e_off >= (SPAN_BITS - WORD_ONE)) ? MAX_OFF : e_off[OFF_W-1:0];
    end

    // word scan
    always_comb begin
        lm_w = r_lm_off[OFF_W-1:POS_W];
        if (r_word < lm_w) begin
            below = WORD_ONES;
        end else if (r_word == lm_w) begin
            below = (WORD_ONE << r_lm_off[POS_W-1:0]) - WORD_ONE;
        end else begin
            below = '0;
        end
        eff     = rd_word | below;
        is_hiw  = r_word == r_hi[OFF_W-1:POS_W];
        is_last = r_word == LAST_WORD;
        range_m = (WORD_ONES << r_pos) &
                  (is_hiw ? (WORD_ONES >> (POS_W'(WORD_BITS - 1) - r_hi[POS_W-1:0]))
                          : WORD_ONES);

        mark_dup = eff[r_pos];

        adv_hit = |(~eff);
        adv_p   = first_one(~eff);

        cand     = ~eff & range_m;
        cand_hit = |cand;
        cand_p   = first_one(cand);

        term_r     = eff | ~range_m;
        term_r_hit = |term_r;
        term_r_p   = first_one(term_r);

        term_s     = term_r & ((WORD_ONES << cand_p) << 1);
        term_s_hit = |term_s;
        term_s_p   = first_one(term_s);

        if (r_run) begin
            qry_fin = term_r_hit || is_hiw;
        end else if (cand_hit) begin
            qry_fin = term_s_hit || is_hiw;
        end else begin
            qry_fin = is_hiw;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (chk_mark_go) begin
                    n_state = S_MARK;
                end else if (chk_qry_go) begin
                    n_state = S_QRY;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MARK: begin
                n_state = mark_dup ? S_DONE : S_ADV;
            end
            S_ADV: begin
                if (adv_hit || is_last) begin
                    n_state = S_DONE;
                end
            end
            S_QRY: begin
                if (qry_fin) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        o_s_axis_tready = r_state == S_IDLE;
        mem_we     = 1'b0;
        mem_clr    = 1'b0;
        mem_wdata  = rd_word | (WORD_ONE << r_pos);
        n_mode     = r_mode;
        n_h        = r_h;
        n_endh     = r_endh;
        n_base     = r_base;
        n_lm       = r_lm;
        n_lm_off   = r_lm_off;
        n_word     = r_word;
        n_pos      = r_pos;
        n_hi       = r_hi;
        n_run      = r_run;
        n_status   = r_status;
        n_found    = r_found;
        n_rs_off   = r_rs_off;
        n_re_off   = r_re_off;
        n_out_vld  = r_out_vld && !i_m_axis_tready;
        n_out_data = r_out_data;
        n_out_user = r_out_user;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_mode = i_s_axis_tuser[0];
                    n_h    = i_s_axis_tdata[WORD_BITS-1:0];
                    n_endh = i_s_axis_tdata[2*WORD_BITS-1:WORD_BITS];
                end
            end
            S_CHECK: begin
                n_found  = 1'b0;
                n_run    = 1'b0;
                n_status = ST_NEW;
                n_hi     = q_hi;
                if (r_mode == MODE_MARK) begin
                    priority if (mark_low) begin
                        n_status = ST_LOW;
                    end else if (mark_out) begin
                        n_status = ST_OUT;
                    end else begin
                        n_word = h_off[OFF_W-1:POS_W];
                        n_pos  = h_off[POS_W-1:0];
                    end
                end else begin
                    n_word = q_lo[OFF_W-1:POS_W];
                    n_pos  = q_lo[POS_W-1:0];
                end
            end
            S_MARK: begin
                if (mark_dup) begin
                    n_status = ST_DUP;
                end else begin
                    mem_we = 1'b1;
                    n_word = lm_w;
                    n_pos  = r_lm_off[POS_W-1:0];
                end
            end
            S_ADV: begin
                priority if (adv_hit) begin
                    n_lm_off = {r_word, adv_p};
                    n_lm     = r_base + WORD_BITS'({r_word, adv_p});
                end else if (is_last) begin
                    mem_clr  = 1'b1;
                    n_base   = r_base + SPAN_BITS;
                    n_lm     = r_base + SPAN_BITS;
                    n_lm_off = '0;
                end else begin
                    n_word = r_word + WW'(1);
                    n_pos  = '0;
                end
            end
            S_QRY: begin
                if (r_run) begin
                    priority if (term_r_hit) begin
                        n_re_off = {r_word, term_r_p} - OFF_W'(1);
                    end else if (is_hiw) begin
                        n_re_off = r_hi;
                    end
                end else if (cand_hit) begin
                    n_found  = 1'b1;
                    n_run    = 1'b1;
                    n_rs_off = {r_word, cand_p};
                    priority if (term_s_hit) begin
                        n_re_off = {r_word, term_s_p} - OFF_W'(1);
                    end else if (is_hiw) begin
                        n_re_off = r_hi;
                    end
                end
                if (!qry_fin) begin
                    n_word = r_word + WW'(1);
                    n_pos  = '0;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_user = r_status;
                    n_out_data = {
                        {(OUT_TDATA_W - 4*WORD_BITS - 1){1'b0}},
                        r_base,
                        r_lm - WORD_ONE,
                        r_found ? (r_base + WORD_BITS'(r_re_off)) : {WORD_BITS{1'b0}},
                        r_found ? (r_base + WORD_BITS'(r_rs_off)) : {WORD_BITS{1'b0}},
                        r_found
                    };
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_base    <= '0;
            r_lm      <= WORD_ONE;
            r_lm_off  <= OFF_W'(1);
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_base    <= n_base;
            r_lm      <= n_lm;
            r_lm_off  <= n_lm_off;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_h        <= n_h;
        r_endh     <= n_endh;
        r_word     <= n_word;
        r_pos      <= n_pos;
        r_hi       <= n_hi;
        r_run      <= n_run;
        r_status   <= n_status;
        r_found    <= n_found;
        r_rs_off   <= n_rs_off;
        r_re_off   <= n_re_off;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    a_lm_tracks_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lm == r_base + WORD_BITS'(r_lm_off))
        else $error("watermark and its window offset disagree");

    a_lm_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lm_off[OFF_W-1:POS_W] <= LAST_WORD)
        else $error("watermark outside the window");

    a_qry_word_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QRY) |-> (r_word <= r_hi[OFF_W-1:POS_W]))
        else $error("query scan past its last word");

    a_window_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADV && !adv_hit && is_last) |=>
            (r_lm_off == '0 && r_state == S_DONE))
        else $error("window move left the watermark off the base");

endmodule

FILE: tb/rhbw_arrival_checker.sv
// Checker for the received height bitmap block: watches both stream channels,
// keeps its own copy of the arrival bitmap, watermark and window, and compares responses.
// Depends on rhbw_pkg.
module rhbw_arrival_checker
    import rhbw_pkg::*;
#(
    parameter int SPAN_WORDS = DEF_SPAN_WORDS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    input  logic                   i_s_axis_tready,
    // [63:0] height, [127:64] limit_height
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [0] mode
    input  logic [IN_TUSER_W-1:0]  i_s_axis_tuser,
    input  logic                   i_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [0] run_found, [64:1] run_start, [128:65] run_end,
    // [192:129] connected_height, [256:193] window_start, [263:257] zero
    input  logic [OUT_TDATA_W-1:0] i_m_axis_tdata,
    // [1:0] status
    input  logic [OUT_TUSER_W-1:0] i_m_axis_tuser,
    output int                     o_fail_count,
    output int                     o_awaited,
    output int                     o_responses,
    output int                     o_window_moves,
    output logic [63:0]            o_watermark,
    output logic [63:0]            o_window_base
);

    localparam logic [63:0] SPAN_BITS = 64'(SPAN_WORDS * WORD_BITS);

    typedef struct packed {
        t_status     status;
        logic        found;
        logic [63:0] run_start;
        logic [63:0] run_end;
        logic [63:0] connected;
        logic [63:0] base;
    } t_response;

    logic [WORD_BITS-1:0] arrivals [SPAN_WORDS];
    logic [63:0]          window_base;
    logic [63:0]          lowest_missing;
    t_response            awaited_responses [$];
    t_response            want;
    t_response            got;
    int                   fail_count;
    int                   responses;
    int                   window_moves;

    function automatic int word_of(input logic [63:0] off);
        return int'((off >> POS_W) % SPAN_WORDS);
    endfunction

    function automatic logic arrived(input logic [63:0] off);
        return arrivals[word_of(off)][off[POS_W-1:0]];
    endfunction

    function automatic t_response apply_request(input logic mode, input logic [63:0] h,
                                                input logic [63:0] e);
        t_response   r;
        logic [63:0] off;
        logic [63:0] cur;
        r.status    = ST_NEW;
        r.found     = 1'b0;
        r.run_start = '0;
        r.run_end   = '0;
        if (mode == MODE_MARK) begin
            off = h - window_base;
            if (h < lowest_missing) begin
                r.status = ST_LOW;
            end else if (h < window_base || off >= SPAN_BITS) begin
                r.status = ST_OUT;
            end else if (arrived(off)) begin
                r.status = ST_DUP;
            end else begin
                arrivals[word_of(off)][off[POS_W-1:0]] = 1'b1;
                off = lowest_missing - window_base;
                while (off < SPAN_BITS && arrived(off)) begin
                    lowest_missing++;
                    off++;
                end
                if (off >= SPAN_BITS) begin
                    window_base += SPAN_BITS;
                    lowest_missing = window_base;
                    foreach (arrivals[i]) arrivals[i] = '0;
                    window_moves++;
                end
            end
        end else if (h <= e) begin
            for (off = '0; off < SPAN_BITS; off++) begin
                cur = window_base + off;
                if (cur < window_base || cur > e) break;
                if (cur >= h) begin
                    if (!arrived(off)) begin
                        if (!r.found) r.run_start = cur;
                        r.found   = 1'b1;
                        r.run_end = cur;
                    end else if (r.found) begin
                        break;
                    end
                end
            end
        end
        r.connected = lowest_missing - 64'd1;
        r.base      = window_base;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (arrivals[i]) arrivals[i] = '0;
            arrivals[0]    = WORD_ONE;
            window_base    = '0;
            lowest_missing = 64'd1;
            awaited_responses.delete();
            fail_count     = 0;
            responses      = 0;
            window_moves   = 0;
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                responses++;
                got.status    = t_status'(i_m_axis_tuser[1:0]);
                got.found     = i_m_axis_tdata[0];
                got.run_start = i_m_axis_tdata[64:1];
                got.run_end   = i_m_axis_tdata[128:65];
                got.connected = i_m_axis_tdata[192:129];
                got.base      = i_m_axis_tdata[256:193];
                if (awaited_responses.size() == 0) begin
                    if (fail_count < 10)
                        $display("response %0d arrived with no request outstanding", responses);
                    fail_count++;
                end else begin
                    want = awaited_responses.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10) begin
                            $display("response %0d mismatch (expected / actual):", responses);
                            $display("  status %0d / %0d  found %0b / %0b",
                                     want.status, got.status, want.found, got.found);
                            $display("  run %h..%h / %h..%h",
                                     want.run_start, want.run_end, got.run_start, got.run_end);
                            $display("  connected %h / %h  window %h / %h",
                                     want.connected, got.connected, want.base, got.base);
                        end
                        fail_count++;
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                awaited_responses = {awaited_responses, apply_request(i_s_axis_tuser[0],
                    i_s_axis_tdata[63:0], i_s_axis_tdata[127:64])};
        end
        o_fail_count   = fail_count;
        o_awaited      = awaited_responses.size();
        o_responses    = responses;
        o_window_moves = window_moves;
        o_watermark    = lowest_missing;
        o_window_base  = window_base;
    end

endmodule

FILE: tb/testbench.sv
// Top of the received height bitmap testbench: clock, reset, request and response
// pacing, directed and random marks and gap queries, watchdog and verdict.
// Depends on rhbw_pkg, received_height_bitmap_watermark and rhbw_arrival_checker.
module testbench;
    import rhbw_pkg::*;

    localparam int          SPAN        = DEF_SPAN_WORDS;
    localparam int          REQUESTS    = 1350;
    localparam int          LONG_HOLD   = 300;
    localparam int          IDLE_LIMIT  = 2000;
    localparam logic [63:0] TOP_HEIGHT  = '1;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_valid  = 1'b0;
    logic                   s_ready;
    logic [IN_TDATA_W-1:0]  s_data   = '0;
    logic [IN_TUSER_W-1:0]  s_user   = '0;
    logic                   m_valid;
    logic                   m_ready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_data;
    logic [OUT_TUSER_W-1:0] m_user;

    int          fail_count;
    int          awaited;
    int          responses;
    int          window_moves;
    logic [63:0] watermark;
    logic [63:0] window_base;

    int   marks        = 0;
    int   queries      = 0;
    int   holds_asked  = 0;
    int   holds_served = 0;
    int   ready_left   = 0;
    logic steady       = 1'b0;

    always #4 clk = ~clk;

    received_height_bitmap_watermark #(
        .SPAN_WORDS(SPAN)
    ) u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    rhbw_arrival_checker #(
        .SPAN_WORDS(SPAN)
    ) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .i_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .i_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .i_m_axis_tdata  (m_data),
        .i_m_axis_tuser  (m_user),
        .o_fail_count    (fail_count),
        .o_awaited       (awaited),
        .o_responses     (responses),
        .o_window_moves  (window_moves),
        .o_watermark     (watermark),
        .o_window_base   (window_base)
    );

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(0, 2);
        if (r < 95) return $urandom_range(3, 10);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [63:0] any_height();
        return {$urandom, $urandom};
    endfunction

    // receiver: random stalls, a steady stretch of ready, and the long hold-off on request
    always @(negedge clk) begin
        if (ready_left > 0) begin
            ready_left <= ready_left - 1;
        end else if (holds_served != holds_asked) begin
            holds_served <= holds_served + 1;
            m_ready      <= 1'b0;
            ready_left   <= LONG_HOLD;
        end else if (steady) begin
            m_ready <= 1'b1;
        end else if ($urandom_range(0, 99) < 55) begin
            m_ready    <= 1'b1;
            ready_left <= $urandom_range(0, 5);
        end else begin
            m_ready    <= 1'b0;
            ready_left <= idle_length();
        end
    end

    task automatic send_req(input logic mode, input logic [63:0] h, input logic [63:0] e);
        int gap;
        gap = (steady || $urandom_range(0, 99) < 45) ? 0 : idle_length();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= mode;
        s_data  <= {e, h};
        do @(posedge clk); while (!s_ready);
        @(negedge clk);
        if (mode == MODE_MARK) marks++;
        else queries++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge clk); while (awaited != 0);
    endtask

    task automatic mark_in_random_order(input logic [63:0] first, input int count);
        logic [63:0] batch [$];
        logic [63:0] t;
        int          j;
        for (int i = 0; i < count; i++) batch = {batch, first + 64'(i)};
        for (int i = count - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            t        = batch[i];
            batch[i] = batch[j];
            batch[j] = t;
        end
        foreach (batch[i]) send_req(MODE_MARK, batch[i], any_height());
    endtask

    task automatic gap_query(input logic [63:0] w, input logic [63:0] b);
        logic [63:0] h;
        logic [63:0] e;
        case ($urandom_range(0, 5))
            0: h = w - 64'($urandom_range(0, 10));
            1: h = b + 64'($urandom_range(0, 255));
            2: h = b - 64'($urandom_range(1, 400));
            3: h = any_height();
            4: h = w;
            default: h = b + 64'($urandom_range(200, 320));
        endcase
        case ($urandom_range(0, 4))
            0: e = h + 64'($urandom_range(0, 20));
            1: e = h + 64'($urandom_range(0, 300));
            2: e = TOP_HEIGHT;
            3: e = h - 64'($urandom_range(1, 5));
            default: e = any_height();
        endcase
        send_req(MODE_QUERY, h, e);
    endtask

    task automatic random_scenario();
        logic [63:0] w;
        logic [63:0] b;
        logic [63:0] h;
        int          pick;
        w    = watermark;
        b    = window_base;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            mark_in_random_order(w + 64'($urandom_range(0, 40)), $urandom_range(1, 16));
        end else if (pick < 47) begin
            // fill well past the watermark, then close the hole
            mark_in_random_order(w + 64'd1, $urandom_range(60, 140));
            send_req(MODE_MARK, w, any_height());
        end else if (pick < 72) begin
            gap_query(w, b);
        end else if (pick < 80) begin
            if ($urandom_range(0, 1) == 0) begin
                send_req(MODE_MARK, w - 64'($urandom_range(1, 20)), any_height());
            end else begin
                h = w + 64'($urandom_range(1, 10));
                send_req(MODE_MARK, h, any_height());
                send_req(MODE_MARK, h, any_height());
            end
        end else if (pick < 88) begin
            if ($urandom_range(0, 3) != 0)
                h = b + 64'(SPAN * WORD_BITS) + 64'($urandom_range(0, 600));
            else
                h = b - 64'($urandom_range(1, 300));
            send_req(MODE_MARK, h, any_height());
        end else begin
            send_req(logic'($urandom_range(0, 1)), any_height(), any_height());
        end
    endtask

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle = 0;
            else idle++;
        end
        $display("received_height_bitmap_watermark verification failed");
        $finish;
    end

    initial begin : stimulus
        int next_hold;
        int paused;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_req(MODE_QUERY, 64'd0, TOP_HEIGHT);
        send_req(MODE_QUERY, 64'd10, 64'd5);
        send_req(MODE_QUERY, TOP_HEIGHT, TOP_HEIGHT);
        send_req(MODE_QUERY, 64'd0, 64'd0);
        send_req(MODE_MARK, 64'd0, 64'd0);
        send_req(MODE_MARK, TOP_HEIGHT, 64'd0);
        send_req(MODE_MARK, 64'd256, 64'd0);
        send_req(MODE_MARK, 64'd5, 64'd0);
        send_req(MODE_MARK, 64'd5, 64'd0);
        send_req(MODE_MARK, 64'd1, TOP_HEIGHT);
        send_req(MODE_QUERY, 64'd0, 64'd10);
        send_req(MODE_MARK, 64'd63, 64'd0);
        send_req(MODE_MARK, 64'd64, 64'd0);
        send_req(MODE_MARK, 64'd255, 64'd0);
        send_req(MODE_QUERY, 64'd60, 64'd70);
        send_req(MODE_QUERY, 64'd2, 64'd3);
        send_req(MODE_QUERY, 64'd6, TOP_HEIGHT);
        send_req(MODE_MARK, 64'd2, TOP_HEIGHT);
        send_req(MODE_QUERY, 64'd0, 64'd2);
        send_req(MODE_MARK, 64'd3, 64'd0);
        send_req(MODE_MARK, 64'd4, 64'd0);
        send_req(MODE_QUERY, 64'd255, TOP_HEIGHT);
        send_req(MODE_QUERY, 64'd200, 64'd254);
        drain();

        next_hold = 500;
        paused    = 0;
        while (marks + queries < REQUESTS) begin
            steady <= (marks + queries >= 300 && marks + queries < 420);
            if (marks + queries >= next_hold) begin
                holds_asked <= holds_asked + 1;
                next_hold   += 600;
            end
            if (!paused && marks + queries >= 800) begin
                drain();
                paused = 1;
            end
            random_scenario();
        end
        drain();
        repeat (20) @(negedge clk);

        $display("Sent %0d marks and %0d gap queries with random pacing and %0d long stalls.",
                 marks, queries, holds_served);
        $display("Checked %0d responses; the arrival window moved on %0d times.",
                 responses, window_moves);
        if (fail_count == 0 && awaited == 0)
            $display("received_height_bitmap_watermark verification clean");
        else
            $display("received_height_bitmap_watermark verification failed");
        $finish;
    end

endmodule

FILE: received_height_bitmap_watermark.f
hw/rtl/rhbw_pkg.sv
hw/rtl/rhbw_bitmap.sv
hw/rtl/received_height_bitmap_watermark.sv
tb/rhbw_arrival_checker.sv
tb/testbench.sv
